// ----- rtl/five_point_stencil_sweep_assert.svh -----
// Assertion macros for the stencil sweep checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef FIVE_POINT_STENCIL_SWEEP_ASSERT_SVH
`define FIVE_POINT_STENCIL_SWEEP_ASSERT_SVH

// Same-cycle implication.
`define FPSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fpss_pkg.sv -----
package fpss_pkg;

    localparam int VALUE_BITS    = 16;
    localparam int SUM_BITS      = VALUE_BITS + 3;
    localparam int CNT_BITS      = 3;
    localparam int RISE_BITS     = VALUE_BITS + 1;
    localparam int SIDE_BITS     = 6;
    localparam int THR_BITS      = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int MAX_SIDE_DEF  = 32;
    localparam int QUEUE_DEPTH   = 4;

    // Reciprocal multiply: floor(x/d) = (x * ceil(2^K/d)) >> K, exact for x < 2^SUM_BITS.
    localparam int RECIP_SHIFT = SUM_BITS + 5;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(64'd1 << RECIP_SHIFT);
    localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(64'd1 << (RECIP_SHIFT - 1));
    localparam logic [RECIP_BITS-1:0] RECIP_3 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
    localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(64'd1 << (RECIP_SHIFT - 2));
    localparam logic [RECIP_BITS-1:0] RECIP_5 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);

    localparam logic [SIDE_BITS-1:0] GRID_SIDE_RST = SIDE_BITS'(32);
    localparam logic [THR_BITS-1:0]  THRESHOLD_RST = THR_BITS'(41);

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_SIDE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic signed [RISE_BITS-1:0] RISE_MIN = {1'b1, {VALUE_BITS{1'b0}}};

    // One averaging job handed from the front to the back.
    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [CNT_BITS-1:0]   cnt;
        logic [VALUE_BITS-1:0] old;
        logic                  last;
    } op_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]        new_value;
        logic                         sweep_end;
        logic signed [RISE_BITS-1:0]  max_rise;
        logic                         more_needed;
    } res_t;

    function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
        logic [RECIP_BITS-1:0] r;
        case (cnt)
            3'd1:    r = RECIP_1;
            3'd2:    r = RECIP_2;
            3'd3:    r = RECIP_3;
            3'd4:    r = RECIP_4;
            3'd5:    r = RECIP_5;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/five_point_stencil_sweep.sv -----
// A sample below row 0 yields the result for the row above: two row store reads, a sum,
// then the op queue, the back's product register and the result queue. Full is high
// until the sum is pushed; row 0 is only stored. The last sample flushes the last row.
// Reset (rst_n, async, active low): indices to zero, grid_side 32, threshold 41,
// queues empty, largest rise to its most negative value; the row store is not cleared.
module five_point_stencil_sweep
    import fpss_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_wdata,
    // sample side
    input  logic                         push,
    output logic                         full,
    input  logic [VALUE_BITS-1:0]        sample,
    // result side
    output logic                         empty,
    input  logic                         pop,
    output logic [VALUE_BITS-1:0]        new_value,
    output logic                         sweep_end,
    output logic signed [RISE_BITS-1:0]  max_rise,
    output logic                         more_needed
);

    localparam int NW = $clog2(MAX_SIDE + 1);

    logic [SIDE_BITS-1:0] grid_side_reg, grid_side_next;
    logic [THR_BITS-1:0]  threshold_reg, threshold_next;

    logic                 restart;
    logic [NW-1:0]        side;

    op_t                  op_in, op_out;
    logic                 op_push, op_full, op_pop, op_empty;
    res_t                 res_in, res_out;
    logic                 res_push, res_full;

    // Any grid_side write restarts the sweep; threshold writes do not.
    assign restart = cfg_we && (cfg_index == CFG_GRID_SIDE);

    always_comb
    begin
        grid_side_next = grid_side_reg;
        threshold_next = threshold_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_SIDE: grid_side_next = cfg_wdata[SIDE_BITS-1:0];
                CFG_THRESHOLD: threshold_next = cfg_wdata[THR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= GRID_SIDE_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else
        begin
            grid_side_reg <= grid_side_next;
            threshold_reg <= threshold_next;
        end
    end

    // Side in use: zero acts as one, anything past MAX_SIDE is clamped.
    always_comb
    begin
        if (grid_side_reg == '0)
        begin
            side = NW'(1);
        end
        else if (grid_side_reg > SIDE_BITS'(MAX_SIDE))
        begin
            side = NW'(MAX_SIDE);
        end
        else
        begin
            side = NW'(grid_side_reg);
        end
    end

    // Front: walks the raster, gathers the five-point neighborhood from the row store.
    fpss_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .side    (side),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .op_push (op_push),
        .op      (op_in),
        .op_full (op_full)
    );

    // Short job queue between the two halves so the flush can run ahead.
    fpss_queue #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_in),
        .full  (op_full),
        .pop   (op_pop),
        .dout  (op_out),
        .empty (op_empty)
    );

    // Back: divide by neighbor count, track largest rise, tag the sweep end.
    fpss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .threshold (threshold_reg),
        .op        (op_out),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    // Output queue; a transfer happens on pop while not empty.
    fpss_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign new_value   = res_out.new_value;
    assign sweep_end   = res_out.sweep_end;
    assign max_rise    = res_out.max_rise;
    assign more_needed = res_out.more_needed;

endmodule

// ----- rtl/fpss_queue.sv -----
module fpss_queue
    import fpss_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    // DEPTH must be a power of two so the pointers wrap on their own.
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [IW:0]      count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == (IW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + IW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + IW'(1) : rd_ptr_reg;
        count_next  = count_reg + (IW+1)'(push_ok) - (IW+1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/fpss_front.sv -----
module fpss_front
    import fpss_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  logic [$clog2(MAX_SIDE+1)-1:0]     side,
    input  logic                              push,
    output logic                              full,
    input  logic [VALUE_BITS-1:0]             sample,
    output logic                              op_push,
    output op_t                               op,
    input  logic                              op_full
);

    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW    = $clog2(2 * MAX_SIDE);
    localparam int DEPTH = 2 * MAX_SIDE;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD2  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;
    localparam logic [1:0] ST_FRD1 = 2'd3;

    // Two row buffers picked by row parity.
    logic [VALUE_BITS-1:0] row_store [DEPTH];

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         row_reg, row_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [CW-1:0]         fcol_reg, fcol_next;
    logic                  flush_reg, flush_next;
    logic [VALUE_BITS-1:0] sample_reg, sample_next;
    logic [VALUE_BITS-1:0] cen_reg, cen_next;
    logic [VALUE_BITS-1:0] vert_reg, vert_next;
    logic [VALUE_BITS-1:0] rd_a_reg, rd_b_reg;

    logic                  accept;
    logic [NW-1:0]         side_m1;
    logic                  row_last, col_last, fcol_last;
    logic [CW-1:0]         ctx_col;
    logic                  ctx_pc, ctx_has_v, has_l, has_r;
    logic                  phase1, phase2, rd_en;
    logic [AW-1:0]         rd_addr_a, rd_addr_b, wr_addr;
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_data;

    function automatic logic [AW-1:0] addr_of(input logic p, input logic [CW-1:0] c);
        return p ? AW'(MAX_SIDE) + AW'(c) : AW'(c);
    endfunction

    assign full      = (state_reg != ST_IDLE);
    assign accept    = push && (state_reg == ST_IDLE);
    assign side_m1   = side - NW'(1);
    assign row_last  = (NW'(row_reg) == side_m1);
    assign col_last  = (NW'(col_reg) == side_m1);
    assign fcol_last = (NW'(fcol_reg) == side_m1);

    // Emit mode averages the row above the arriving sample; flush mode the current row.
    assign ctx_col   = flush_reg ? fcol_reg : col_reg;
    assign ctx_pc    = flush_reg ? row_reg[0] : ~row_reg[0];
    assign ctx_has_v = flush_reg ? (row_reg != '0) : (row_reg > CW'(1));
    assign has_l     = (ctx_col != '0);
    assign has_r     = ((NW'(ctx_col) + NW'(1)) < side);

    // Read phase 1: centre and vertical; phase 2: left and right.
    assign phase1 = (accept && (row_reg != '0)) || (state_reg == ST_FRD1);
    assign phase2 = (state_reg == ST_RD2);
    assign rd_en  = phase1 || phase2;

    always_comb
    begin
        if (phase2)
        begin
            rd_addr_a = addr_of(ctx_pc, has_l ? ctx_col - CW'(1) : ctx_col);
            rd_addr_b = addr_of(ctx_pc, has_r ? ctx_col + CW'(1) : ctx_col);
        end
        else
        begin
            rd_addr_a = addr_of(ctx_pc, ctx_col);
            rd_addr_b = addr_of(~ctx_pc, ctx_col);
        end
    end

    assign op_push = (state_reg == ST_PUSH) && !op_full;

    always_comb
    begin
        op.sum = SUM_BITS'(cen_reg)
               + (ctx_has_v ? SUM_BITS'(vert_reg) : '0)
               + (has_l ? SUM_BITS'(rd_a_reg) : '0)
               + (has_r ? SUM_BITS'(rd_b_reg) : '0)
               + (flush_reg ? '0 : SUM_BITS'(sample_reg));
        op.cnt = CNT_BITS'(1) + CNT_BITS'(ctx_has_v) + CNT_BITS'(has_l)
               + CNT_BITS'(has_r) + CNT_BITS'(!flush_reg);
        op.old  = cen_reg;
        op.last = flush_reg && fcol_last;
    end

    // The new sample goes in after its slot's old value has been read.
    assign wr_en   = (accept && (row_reg == '0)) || (op_push && !flush_reg);
    assign wr_addr = addr_of(row_reg[0], col_reg);
    assign wr_data = (state_reg == ST_IDLE) ? sample : sample_reg;

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        fcol_next   = fcol_reg;
        flush_next  = flush_reg;
        sample_next = accept ? sample : sample_reg;
        cen_next    = phase2 ? rd_a_reg : cen_reg;
        vert_next   = phase2 ? rd_b_reg : vert_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (row_reg != '0)
                    begin
                        state_next = ST_RD2;
                    end
                    else if (row_last && col_last)
                    begin
                        flush_next = 1'b1;
                        fcol_next  = '0;
                        state_next = ST_FRD1;
                    end
                    else if (col_last)
                    begin
                        col_next = '0;
                        row_next = row_reg + CW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            ST_RD2:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!op_full)
                begin
                    if (flush_reg)
                    begin
                        if (fcol_last)
                        begin
                            flush_next = 1'b0;
                            row_next   = '0;
                            col_next   = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            fcol_next  = fcol_reg + CW'(1);
                            state_next = ST_FRD1;
                        end
                    end
                    else if (row_last && col_last)
                    begin
                        flush_next = 1'b1;
                        fcol_next  = '0;
                        state_next = ST_FRD1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (col_last)
                        begin
                            col_next = '0;
                            row_next = row_reg + CW'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                end
            end
            ST_FRD1:
            begin
                state_next = ST_RD2;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart)
        begin
            state_next = ST_IDLE;
            row_next   = '0;
            col_next   = '0;
            fcol_next  = '0;
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            fcol_reg  <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            fcol_reg  <= fcol_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        cen_reg    <= cen_next;
        vert_reg   <= vert_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_store[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= row_store[rd_addr_a];
            rd_b_reg <= row_store[rd_addr_b];
        end
    end

endmodule

// ----- rtl/fpss_back.sv -----
module fpss_back
    import fpss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic [THR_BITS-1:0] threshold,
    input  op_t                 op,
    input  logic                op_empty,
    output logic                op_pop,
    output logic                res_push,
    output res_t                res,
    input  logic                res_full
);

    logic                         s1_valid_reg, s1_valid_next;
    logic [PROD_BITS-1:0]         prod_reg, prod_next;
    logic [VALUE_BITS-1:0]        old_reg, old_next;
    logic                         last_reg, last_next;
    logic signed [RISE_BITS-1:0]  max_reg, max_next;

    logic                         s1_ready;
    logic [VALUE_BITS-1:0]        avg;
    logic signed [RISE_BITS-1:0]  rise, new_max;
    logic                         over;

    assign s1_ready = !s1_valid_reg || !res_full;
    assign op_pop   = !op_empty && s1_ready;
    assign res_push = s1_valid_reg && !res_full;

    // Quotient by 1..5 through the reciprocal table.
    assign avg     = prod_reg[RECIP_SHIFT +: VALUE_BITS];
    assign rise    = $signed({1'b0, avg}) - $signed({1'b0, old_reg});
    assign new_max = (rise > max_reg) ? rise : max_reg;
    assign over    = (new_max > $signed({1'b0, threshold}));

    always_comb
    begin
        res.new_value   = avg;
        res.sweep_end   = last_reg;
        res.max_rise    = last_reg ? new_max : '0;
        res.more_needed = last_reg && over;
    end

    always_comb
    begin
        s1_valid_next = op_pop ? 1'b1 : (res_push ? 1'b0 : s1_valid_reg);
        prod_next     = op_pop ? PROD_BITS'(op.sum) * PROD_BITS'(recip(op.cnt)) : prod_reg;
        old_next      = op_pop ? op.old : old_reg;
        last_next     = op_pop ? op.last : last_reg;

        max_next = max_reg;
        if (restart)
        begin
            max_next = RISE_MIN;
        end
        else if (res_push)
        begin
            max_next = last_reg ? RISE_MIN : new_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            max_reg      <= RISE_MIN;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            max_reg      <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        old_reg  <= old_next;
        last_reg <= last_next;
    end

endmodule

// ----- rtl/fpss_checker.sv -----
`include "five_point_stencil_sweep_assert.svh"

module fpss_checker
    import fpss_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [VALUE_BITS-1:0]        new_value,
    input logic                         sweep_end,
    input logic signed [RISE_BITS-1:0]  max_rise,
    input logic                         more_needed
);

    // Summary fields are only carried on the last result.
    `FPSS_ASSERT_IMP(a_mid_clear, !empty && !sweep_end, (max_rise == '0) && !more_needed, "summary on mid-sweep result")

    // A finished sweep saw at least one rise, so the floor value never leaks out.
    `FPSS_ASSERT_IMP(a_end_max_set, !empty && sweep_end, max_rise != RISE_MIN, "max_rise left at reset value")

    // Threshold is unsigned, so the flag needs a positive rise.
    `FPSS_ASSERT_IMP(a_flag_pos, !empty && more_needed, !max_rise[RISE_BITS-1] && (max_rise != '0), "flag without positive rise")

    // Waiting result holds until transferred.
    `FPSS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(new_value) && $stable(sweep_end), "result changed while stalled")

endmodule

bind five_point_stencil_sweep fpss_checker u_fpss_checker (.*);
